@@ rtl/core/dual_crc32c_block_hash_assert.svh @@
// ----------------------------------------------------------------------------
// dual crc32c block hash assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DUAL_CRC32C_BLOCK_HASH_ASSERT_SVH
`define DUAL_CRC32C_BLOCK_HASH_ASSERT_SVH

// same-cycle implication
`define DCBH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DCBH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dcbh_pkg.sv @@
// ----------------------------------------------------------------------------
// dcbh_pkg
// types, constants and crc-32c column tables for the dual block hash
// ----------------------------------------------------------------------------
package dcbh_pkg;

	localparam int unsigned CRC_W      = 32;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned LANES      = WORD_W / SAMPLE_W;
	localparam int unsigned LANE_IDX_W = $clog2(LANES);
	localparam int unsigned BIT_IDX_W  = $clog2(SAMPLE_W);
	localparam int unsigned MAX_TX_SIDE = 64;

	localparam logic [CRC_W-1:0]  POLY_REFLECTED = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0]  LOW_INIT       = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0]  HIGH_INIT      = 32'h9E37_79B9;
	localparam logic [WORD_W-1:0] HIGH_WHITEN    = 64'hA5A5_A5A5_A5A5_A5A5;

	typedef logic [LANE_IDX_W-1:0] lane_idx_t;
	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [CRC_W-1:0]      crc_t;

	typedef logic [WORD_W-1:0][CRC_W-1:0] word_cols_t;
	typedef logic [CRC_W-1:0][CRC_W-1:0]  state_cols_t;

	// per-lane partial crc for both streams
	typedef struct packed {
		crc_t lo;
		crc_t hi;
	} lane_sum_t;

	// handshake control from top to merge stage
	typedef struct packed {
		logic take;
		logic fold;
	} merge_ctrl_t;

	// bit-serial reflected crc, elaboration use only
	function automatic crc_t crc_shift(crc_t r_in, logic [WORD_W-1:0] w_in, int unsigned n);
		crc_t r;
		logic [WORD_W-1:0] w;
		logic fb;
		r = r_in;
		w = w_in;
		for (int unsigned k = 0; k < n; k++) begin
			fb = r[0] ^ w[0];
			r  = r >> 1;
			if (fb) begin
				r = r ^ POLY_REFLECTED;
			end
			w = w >> 1;
		end
		return r;
	endfunction

	// contribution of each word bit from a zero register, followed by z zero bits
	function automatic word_cols_t word_cols(int unsigned z);
		word_cols_t res;
		for (int unsigned j = 0; j < WORD_W; j++) begin
			res[j] = crc_shift(crc_shift('0, WORD_W'(1) << j, WORD_W), '0, z);
		end
		return res;
	endfunction

	// register advanced by n zero bits, one column per register bit
	function automatic state_cols_t state_cols(int unsigned n);
		state_cols_t res;
		for (int unsigned i = 0; i < CRC_W; i++) begin
			res[i] = crc_shift(CRC_W'(1) << i, '0, n);
		end
		return res;
	endfunction

	localparam word_cols_t  WCOL_ONE = word_cols(0);
	localparam word_cols_t  WCOL_TWO = word_cols(WORD_W);
	localparam state_cols_t SCOL_ONE = state_cols(WORD_W);
	localparam state_cols_t SCOL_TWO = state_cols(2 * WORD_W);

	// gf(2) matrix times register
	function automatic crc_t apply_state(state_cols_t cols, crc_t v);
		crc_t res;
		res = '0;
		for (int unsigned i = 0; i < CRC_W; i++) begin
			res = res ^ (v[i] ? cols[i] : '0);
		end
		return res;
	endfunction

endpackage

@@ rtl/core/dcbh_lane.sv @@
// ----------------------------------------------------------------------------
// dcbh_lane
// crc contribution of one 16-bit sample slot and its metadata slice
// ----------------------------------------------------------------------------
module dcbh_lane (
	input  dcbh_pkg::lane_idx_t pos,
	input  dcbh_pkg::sample_t   sample,
	input  dcbh_pkg::sample_t   meta_lo,
	input  dcbh_pkg::sample_t   meta_hi,
	input  logic                last,
	output dcbh_pkg::lane_sum_t sum
);
	import dcbh_pkg::*;

	sample_t whitened;

	assign whitened = sample ^ HIGH_WHITEN[pos * SAMPLE_W +: SAMPLE_W];

	always_comb begin
		logic [LANE_IDX_W+BIT_IDX_W-1:0] bit_idx;
		crc_t lo;
		crc_t hi;
		lo = '0;
		hi = '0;
		for (int k = 0; k < SAMPLE_W; k++) begin
			bit_idx = {pos, BIT_IDX_W'(k)};
			// word bits, pushed one word further when metadata follows
			lo = lo ^ (sample[k] ? (last ? WCOL_TWO[bit_idx] : WCOL_ONE[bit_idx]) : '0);
			hi = hi ^ (whitened[k] ? (last ? WCOL_TWO[bit_idx] : WCOL_ONE[bit_idx]) : '0);
			// metadata word only on the last word
			lo = lo ^ ((last && meta_lo[k]) ? WCOL_ONE[bit_idx] : '0);
			hi = hi ^ ((last && meta_hi[k]) ? WCOL_ONE[bit_idx] : '0);
		end
		sum.lo = lo;
		sum.hi = hi;
	end

endmodule

@@ rtl/core/dcbh_merge.sv @@
// ----------------------------------------------------------------------------
// dcbh_merge
// combines lane sums, folds them into both crc registers, holds the result
// ----------------------------------------------------------------------------
module dcbh_merge (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dcbh_pkg::merge_ctrl_t            ctrl,
	input  dcbh_pkg::lane_sum_t [dcbh_pkg::LANES-1:0] lane_sums,
	input  logic                             last,
	output logic                             last_s1,
	output dcbh_pkg::crc_t                   hash_low_q,
	output dcbh_pkg::crc_t                   hash_high_q
);
	import dcbh_pkg::*;

	crc_t delta_lo;
	crc_t delta_hi;
	crc_t delta_lo_s1;
	crc_t delta_hi_s1;
	crc_t crc_lo_q;
	crc_t crc_hi_q;
	crc_t next_lo;
	crc_t next_hi;

	always_comb begin
		delta_lo = '0;
		delta_hi = '0;
		for (int g = 0; g < LANES; g++) begin
			delta_lo = delta_lo ^ lane_sums[g].lo;
			delta_hi = delta_hi ^ lane_sums[g].hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			delta_lo_s1 <= delta_lo;
			delta_hi_s1 <= delta_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (ctrl.take) begin
			last_s1 <= last;
		end
	end

	// register advanced over one word, or over word plus metadata
	assign next_lo = (last_s1 ? apply_state(SCOL_TWO, crc_lo_q)
	                          : apply_state(SCOL_ONE, crc_lo_q)) ^ delta_lo_s1;
	assign next_hi = (last_s1 ? apply_state(SCOL_TWO, crc_hi_q)
	                          : apply_state(SCOL_ONE, crc_hi_q)) ^ delta_hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_lo_q <= LOW_INIT;
			crc_hi_q <= HIGH_INIT;
		end else if (ctrl.fold) begin
			crc_lo_q <= last_s1 ? LOW_INIT : next_lo;
			crc_hi_q <= last_s1 ? HIGH_INIT : next_hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fold && last_s1) begin
			hash_low_q  <= next_lo;
			hash_high_q <= next_hi;
		end
	end

endmodule

@@ rtl/core/dual_crc32c_block_hash.sv @@
// ----------------------------------------------------------------------------
// dual_crc32c_block_hash
// two-stream reflected crc-32c hash over a residual block
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one 64-bit word per
//   transaction: four 16-bit samples, sample0 in the low bits, in raster
//   order. last_word closes the block; the metadata fields are only
//   looked at on that word.
//   output channel (out_valid / out_stall) carries one transaction per
//   block: hash_low and hash_high.
//   throughput: one word per cycle while in_stall is low. four sample lanes
//   compute their crc contribution in parallel, then the merge stage folds
//   the summed contribution into each crc register with a 32x32 xor matrix,
//   one for a plain word and one for a word followed by metadata.
//   result path: the accepting edge loads the lane stage; folding that last
//   word loads the output register and raises out_valid.
//   stall: non-last words keep flowing while a result waits. a last word
//   held in the lane stage waits only while the output register is full
//   and stalled, and then in_stall is raised.
//   reset: both crc registers load their initial values, nothing is valid.
// ----------------------------------------------------------------------------
module dual_crc32c_block_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  sample0,
	input  logic signed [15:0]  sample1,
	input  logic signed [15:0]  sample2,
	input  logic signed [15:0]  sample3,
	input  logic                last_word,
	input  logic [9:0]          quant_index,
	input  logic [4:0]          skip_context,
	input  logic [2:0]          dc_sign_context,
	input  logic [6:0]          block_width,
	input  logic [6:0]          block_height,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         hash_low,
	output logic [31:0]         hash_high
);
	import dcbh_pkg::*;

	`include "dual_crc32c_block_hash_assert.svh"

	logic [LANES-1:0][SAMPLE_W-1:0] samples;
	logic [WORD_W-1:0]              meta_lo_word;
	logic [WORD_W-1:0]              meta_hi_word;
	lane_sum_t [LANES-1:0]          lane_sums;
	merge_ctrl_t                    ctrl;
	logic                           valid_s1;
	logic                           last_s1;
	logic                           out_valid_q;
	crc_t                           hash_low_q;
	crc_t                           hash_high_q;

	// raw two's complement bits of each sample
	assign samples = {sample3, sample2, sample1, sample0};

	// metadata words, same bit layout as a sample word
	assign meta_lo_word = {22'b0, quant_index, 11'b0, skip_context, 13'b0, dc_sign_context};
	assign meta_hi_word = {25'b0, block_width, 25'b0, block_height};

	// one lane per sample slot
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		dcbh_lane u_lane (
			.pos     (lane_idx_t'(g)),
			.sample  (samples[g]),
			.meta_lo (meta_lo_word[g * SAMPLE_W +: SAMPLE_W]),
			.meta_hi (meta_hi_word[g * SAMPLE_W +: SAMPLE_W]),
			.last    (last_word),
			.sum     (lane_sums[g])
		);
	end

	// lane stage drains unless it holds a last word with nowhere to go
	assign ctrl.fold = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !ctrl.fold;
	assign ctrl.take = in_valid && !in_stall;

	dcbh_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.lane_sums   (lane_sums),
		.last        (last_word),
		.last_s1     (last_s1),
		.hash_low_q  (hash_low_q),
		.hash_high_q (hash_high_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.take) begin
			valid_s1 <= 1'b1;
		end else if (ctrl.fold) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register: loaded by a folded last word, freed by a transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fold && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_low  = hash_low_q;
	assign hash_high = hash_high_q;

	`DCBH_ASSERT_NOW(a_stall_only_on_last, in_stall, valid_s1 && last_s1, "input stalled without a pending last word")
	`DCBH_ASSERT_NOW(a_no_result_overwrite, ctrl.fold && last_s1 && out_valid_q, !out_stall, "result register overwritten while stalled")
	`DCBH_ASSERT_NEXT(a_result_follows_fold, ctrl.fold && last_s1, out_valid, "folded last word did not raise out_valid")
	`DCBH_ASSERT_NEXT(a_take_fills_stage, ctrl.take, valid_s1, "accepted word missing from lane stage")

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dual crc-32c block hash: directed blocks and then
// residual blocks of random length go in, both hashes are predicted per block by a
// bit-serial crc-32c and compared with every result the block hands out
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcbh_pkg::sample_t;
	import dcbh_pkg::crc_t;

	// prediction constants
	localparam crc_t        CASTAGNOLI_REV = 32'h82F6_3B78;
	localparam crc_t        LO_SEED        = 32'hFFFF_FFFF;
	localparam crc_t        HI_SEED        = 32'h9E37_79B9;
	localparam logic [63:0] HI_MASK        = 64'hA5A5_A5A5_A5A5_A5A5;

	localparam int WORD_TARGET = 1800;  // input transactions the run sends at least
	localparam int HOLD_CYCLES = 64;    // long receiver hold-off
	localparam int FLOOD_BLOCKS = 24;   // one-word blocks offered during the hold-off
	localparam int SHOW_LIMIT = 10;

	// one input word with its block metadata
	typedef struct packed {
		sample_t    s0;
		sample_t    s1;
		sample_t    s2;
		sample_t    s3;
		logic       last;
		logic [9:0] qi;
		logic [4:0] skip;
		logic [2:0] dc;
		logic [6:0] bw;
		logic [6:0] bh;
	} word_in_t;

	typedef struct packed {
		crc_t lo;
		crc_t hi;
	} hash_pair_t;

	// directed row: a hash is typed in only where it is known without the predictor
	typedef struct packed {
		word_in_t w;
		bit       lo_k;
		crc_t     lo;
		bit       hi_k;
		crc_t     hi;
	} dir_row_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	localparam int DIR_ROWS = 20;

	// a fresh register that absorbs its own value as the first 32 data bits
	// goes to zero and stays there through zero data and zero metadata
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// low stream cancelled: word = 0x00000000_ffffffff
		'{'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b1, 32'h0000_0000, 1'b0, 32'h0},
		// high stream cancelled: word ^ mask = 0x00000000_9e3779b9
		'{'{16'hDC1C, 16'h3B92, 16'hA5A5, 16'hA5A5, 1'b1, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b1, 32'h0000_0000},
		// all-zero and all-one words, metadata at both ends
		'{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 10'h3FF, 5'h1F, 3'h7, 7'h7F, 7'h7F},
			1'b0, 32'h0, 1'b0, 32'h0},
		// most positive and most negative samples
		'{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 10'h200, 5'h10, 3'h4, 7'd64, 7'd64},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 10'd1, 5'd1, 3'd1, 7'd4, 7'd1},
			1'b0, 32'h0, 1'b0, 32'h0},
		// four-word block, junk metadata on the inner words, zero-sized last word
		'{'{16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0, 10'h3FF, 5'h1F, 3'h7, 7'h7F, 7'h7F},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFC, 1'b0, 10'h155, 5'h0A, 3'h5, 7'h2A, 7'h55},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0, 10'h2AA, 5'h15, 3'h2, 7'h55, 7'h2A},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 1'b1, 10'd7, 5'd3, 3'd6, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		// two-word block, width not a multiple of four, height above the max side
		'{'{16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0, 1'b0, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h0003, 16'hFFFD, 16'h0000, 16'h0001, 1'b1, 10'd100, 5'd9, 3'd3, 7'd6, 7'd65},
			1'b0, 32'h0, 1'b0, 32'h0},
		// raw 7-bit sizes far out of range
		'{'{16'h4000, 16'hC000, 16'h2000, 16'hE000, 1'b1, 10'd512, 5'd16, 3'd0, 7'h7F, 7'h7F},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 1'b1, 10'd33, 5'd2, 3'd7, 7'd68, 7'd100},
			1'b0, 32'h0, 1'b0, 32'h0},
		// five-word block of alternating bit patterns
		'{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 1'b0, 10'd0, 5'd0, 3'd0, 7'd0, 7'd0},
			1'b0, 32'h0, 1'b0, 32'h0},
		'{'{16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b1, 10'h155, 5'h0A, 3'd2, 7'h2A, 7'h55},
			1'b0, 32'h0, 1'b0, 32'h0},
		// mixed small residuals, regular size
		'{'{16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE, 1'b1, 10'd255, 5'd31, 3'd5, 7'd16, 7'd8},
			1'b0, 32'h0, 1'b0, 32'h0}
	};

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block inputs, all known from time zero
	logic              in_valid = 1'b0;
	logic signed [15:0] sample0 = '0;
	logic signed [15:0] sample1 = '0;
	logic signed [15:0] sample2 = '0;
	logic signed [15:0] sample3 = '0;
	logic              last_word = 1'b0;
	logic [9:0]        quant_index = '0;
	logic [4:0]        skip_context = '0;
	logic [2:0]        dc_sign_context = '0;
	logic [6:0]        block_width = '0;
	logic [6:0]        block_height = '0;
	logic              out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [31:0] hash_low;
	logic [31:0] hash_high;

	dual_crc32c_block_hash dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample0         (sample0),
		.sample1         (sample1),
		.sample2         (sample2),
		.sample3         (sample3),
		.last_word       (last_word),
		.quant_index     (quant_index),
		.skip_context    (skip_context),
		.dc_sign_context (dc_sign_context),
		.block_width     (block_width),
		.block_height    (block_height),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hash_low        (hash_low),
		.hash_high       (hash_high)
	);

	// running crc of the block in flight, as the block should hold it
	crc_t lo_run = LO_SEED;
	crc_t hi_run = HI_SEED;

	// hashes still owed by the block, oldest first
	hash_pair_t hash_q[$];
	hash_pair_t hash_want;

	int bad_cnt = 0;       // results with a wrong field plus results nobody asked for
	int hash_seen = 0;
	int words_sent = 0;
	int blocks_sent = 0;
	int longest_block = 0;
	int cur_block = 0;
	int in_held = 0;       // cycles the block pushed back on a waiting word
	int burst_left = 0;

	// long hold-off handshake between stimulus and receiver
	int hold_asked = 0;
	int hold_done = 0;

	rx_mode_t rx_mode = RX_FREE;
	int rx_left = 0;
	int beat = 0;

	// reflected crc-32c, one data bit per shift, lsb first
	function automatic crc_t crc32c_feed(crc_t r_in, logic [63:0] d_in);
		crc_t r;
		logic [63:0] d;
		r = r_in;
		d = d_in;
		for (int k = 0; k < 64; k++) begin
			if (r[0] ^ d[0]) begin
				r = (r >> 1) ^ CASTAGNOLI_REV;
			end else begin
				r = r >> 1;
			end
			d = d >> 1;
		end
		return r;
	endfunction

	// absorb one word; on the last word fold in the metadata, hand out both
	// hashes and reseed
	task automatic hash_word(input word_in_t w, output bit done, output hash_pair_t h);
		logic [63:0] word;
		word = {w.s3, w.s2, w.s1, w.s0};
		lo_run = crc32c_feed(lo_run, word);
		hi_run = crc32c_feed(hi_run, word ^ HI_MASK);
		done = w.last;
		h = '0;
		if (w.last) begin
			lo_run = crc32c_feed(lo_run, {22'd0, w.qi, 11'd0, w.skip, 13'd0, w.dc});
			hi_run = crc32c_feed(hi_run, {25'd0, w.bw, 25'd0, w.bh});
			h.lo = lo_run;
			h.hi = hi_run;
			lo_run = LO_SEED;
			hi_run = HI_SEED;
		end
	endtask

	// offer one word and hold it until the block takes it; the hashes are
	// predicted at the accepting edge, a typed-in value overrides a field
	task automatic put_word(input word_in_t w, input bit lo_k = 1'b0, input crc_t lo_v = '0,
			input bit hi_k = 1'b0, input crc_t hi_v = '0);
		bit done;
		hash_pair_t h;
		in_valid        <= 1'b1;
		sample0         <= w.s0;
		sample1         <= w.s1;
		sample2         <= w.s2;
		sample3         <= w.s3;
		last_word       <= w.last;
		quant_index     <= w.qi;
		skip_context    <= w.skip;
		dc_sign_context <= w.dc;
		block_width     <= w.bw;
		block_height    <= w.bh;
		do @(posedge clk); while (in_stall);
		hash_word(w, done, h);
		words_sent++;
		cur_block++;
		if (done) begin
			if (lo_k) begin
				h.lo = lo_v;
			end
			if (hi_k) begin
				h.hi = hi_v;
			end
			hash_q.push_back(h);
			blocks_sent++;
			if (cur_block > longest_block) begin
				longest_block = cur_block;
			end
			cur_block = 0;
		end
	endtask

	// sender pacing: bursts of back-to-back words, then a short gap;
	// every so often a long burst gives a stretch with no idling at all
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 120);
			end else begin
				burst_left = $urandom_range(1, 16);
			end
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// residual-like samples: small values most often, with zeros, extremes and full noise
	function automatic sample_t rand_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: begin
				return '0;
			end
			2, 3, 4, 5: begin
				return sample_t'(int'($urandom_range(0, 128)) - 64);
			end
			6: begin
				case ($urandom_range(0, 3))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	// random word; metadata is junk on inner words and mostly well formed on
	// the last one, with raw 7-bit sizes now and then
	function automatic word_in_t rand_word(bit last);
		word_in_t w;
		w.s0   = rand_sample();
		w.s1   = rand_sample();
		w.s2   = rand_sample();
		w.s3   = rand_sample();
		w.last = last;
		w.qi   = 10'($urandom);
		w.skip = 5'($urandom);
		w.dc   = 3'($urandom);
		if (last && $urandom_range(0, 4) != 0) begin
			w.bw = 7'(4 * $urandom_range(1, 16));
			w.bh = 7'($urandom_range(1, 64));
		end else begin
			w.bw = 7'($urandom);
			w.bh = 7'($urandom);
		end
		return w;
	endfunction

	// block length: short blocks dominate, a few reach deep into large sizes
	function automatic int rand_len();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			return $urandom_range(1, 8);
		end else if (pick < 19) begin
			return $urandom_range(9, 64);
		end
		return $urandom_range(65, 256);
	endfunction

	// receiver: random stall moods of random length, plus the long hold-off
	// on request, counted here in its own cycles
	initial begin
		@(posedge clk);
		forever begin
			if (hold_done != hold_asked) begin
				hold_done = hold_asked;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(8, 80);
				end
				rx_left--;
				beat++;
				case (rx_mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					RX_BEAT:  out_stall <= (beat % 3 == 0);
					default:  out_stall <= 1'b0;
				endcase
			end
			@(posedge clk);
		end
	end

	// result checker: each hash pair against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall) begin
			in_held++;
		end
		if (arst_n && out_valid && !out_stall) begin
			hash_seen++;
			if (hash_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= SHOW_LIMIT) begin
					$display("[%0t] unexpected hash low=%h high=%h", $realtime,
						hash_low, hash_high);
				end
			end else begin
				hash_want = hash_q.pop_front();
				if (hash_low !== hash_want.lo || hash_high !== hash_want.hi) begin
					bad_cnt++;
					if (bad_cnt <= SHOW_LIMIT) begin
						$display("[%0t] hash mismatch low exp=%h got=%h high exp=%h got=%h",
							$realtime, hash_want.lo, hash_low, hash_want.hi, hash_high);
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int len;
		int drain;
		bit flooded;
		bit drained;
		flooded = 1'b0;
		drained = 1'b0;
		drain = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (int i = 0; i < DIR_ROWS; i++) begin
			put_word(DIR_TAB[i].w, DIR_TAB[i].lo_k, DIR_TAB[i].lo, DIR_TAB[i].hi_k,
				DIR_TAB[i].hi);
			pace();
		end

		// random blocks
		while (words_sent < WORD_TARGET) begin
			if (!flooded && words_sent >= 700) begin
				// receiver holds off while one-word blocks keep coming, so the
				// result path fills and the input gets pushed back
				flooded = 1'b1;
				hold_asked++;
				for (int i = 0; i < FLOOD_BLOCKS; i++) begin
					put_word(rand_word(1'b1));
				end
			end
			if (!drained && words_sent >= 1200) begin
				// sender goes quiet until every owed hash has come back
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (hash_q.size() != 0);
			end
			len = rand_len();
			for (int i = 0; i < len; i++) begin
				put_word(rand_word(i == len - 1));
				pace();
			end
		end
		in_valid <= 1'b0;

		// let the owed hashes drain, then keep watching for strays
		while (hash_q.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);

		$display("run covered %0d words in %0d blocks (longest %0d words), %0d hashes seen",
			words_sent, blocks_sent, longest_block, hash_seen);
		$display("input pushed back on %0d cycles, %0d bad hashes, %0d still owed",
			in_held, bad_cnt, hash_q.size());
		if (bad_cnt == 0 && hash_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

@@ dual_crc32c_block_hash.f @@
+incdir+rtl/core
rtl/core/dcbh_pkg.sv
rtl/core/dcbh_lane.sv
rtl/core/dcbh_merge.sv
rtl/core/dual_crc32c_block_hash.sv
bench/tb.sv
